/* hdl/isort_pkg.sv */
package isort_pkg;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

/* hdl/isort_cell.sv */
module isort_cell #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  isort_pkg::cell_ctrl_t        ctrl_i,
  input  logic signed [VALUE_BITS-1:0] ins_value_i,
  input  logic                         occ_i,
  input  logic                         prev_occ_i,
  input  logic                         prev_greater_i,
  input  logic signed [VALUE_BITS-1:0] prev_value_i,
  input  logic signed [VALUE_BITS-1:0] next_value_i,
  output logic signed [VALUE_BITS-1:0] value_o,
  output logic                         greater_o
);

  logic signed [VALUE_BITS-1:0] value_q, value_d;
  logic                         take;

  assign greater_o = occ_i && (value_q > ins_value_i);
  assign take      = greater_o || (!occ_i && prev_occ_i);
  assign value_o   = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift) begin
      value_d = next_value_i;
    end else if (ctrl_i.insert && take) begin
      // open the slot: take the word from below if it also moves up
      value_d = prev_greater_i ? prev_value_i : ins_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

/* hdl/insertion_sorter.sv */
// Insertion sorter for signed words.
// Input channel: present value_i and set_end_i with start_i high; a word is
// taken at a rising edge where start_i is high and busy_o is low. Each word
// is inserted into a row of MAX_ITEMS cells: every cell compares the new
// word with its own and moves up or takes it, so loading runs at one word
// per cycle. Equal words keep their arrival order.
// The word with set_end_i high closes the set. From the next cycle busy_o is
// high and the row shifts down one cell per cycle, giving one result per
// cycle on sorted_value_o with strobe_o high, min(n, MAX_ITEMS) results for
// a set of n words; final_item_o marks the last. The first result appears in
// the cycle after the closing word is taken. busy_o falls after the last
// result.
// Words arriving while the row is full are dropped; overflowed_o is then
// high on every result of that set.
// Results cannot be held off: each stands for exactly one cycle.
// Reset empties the row and clears the overflow flag; the cell contents are
// not cleared, as occupancy follows the fill count alone.
module insertion_sorter #(
  parameter int MAX_ITEMS  = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                         set_end_i,
  output logic                         strobe_o,
  output logic signed [VALUE_BITS-1:0] sorted_value_o,
  output logic                         final_item_o,
  output logic                         overflowed_o
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  isort_pkg::state_e     state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic                  accept;
  logic                  full;
  isort_pkg::cell_ctrl_t ctrl;

  logic signed [VALUE_BITS-1:0] cell_value [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]         cell_greater;
  logic [MAX_ITEMS-1:0]         cell_occ;

  assign busy_o = (state_q == isort_pkg::ST_DRAIN);
  assign accept = start_i && !busy_o;
  assign full   = (cnt_q == CNT_W'(MAX_ITEMS));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    case (state_q)
      isort_pkg::ST_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
            cnt_d       = cnt_q + 1'b1;
          end
          if (set_end_i) begin
            state_d = isort_pkg::ST_DRAIN;
          end
        end
      end
      isort_pkg::ST_DRAIN: begin
        ctrl.shift = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = isort_pkg::ST_LOAD;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = isort_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isort_pkg::ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                         prev_occ;
    logic                         prev_greater;
    logic signed [VALUE_BITS-1:0] prev_value;
    logic signed [VALUE_BITS-1:0] next_value;

    assign cell_occ[i] = (CNT_W'(i) < cnt_q);

    if (i == 0) begin : g_first
      assign prev_occ     = 1'b1;
      assign prev_greater = 1'b0;
      assign prev_value   = '0;
    end else begin : g_inner
      assign prev_occ     = cell_occ[i-1];
      assign prev_greater = cell_greater[i-1];
      assign prev_value   = cell_value[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign next_value = '0;
    end else begin : g_mid
      assign next_value = cell_value[i+1];
    end

    isort_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .ins_value_i   (value_i),
      .occ_i         (cell_occ[i]),
      .prev_occ_i    (prev_occ),
      .prev_greater_i(prev_greater),
      .prev_value_i  (prev_value),
      .next_value_i  (next_value),
      .value_o       (cell_value[i]),
      .greater_o     (cell_greater[i])
    );
  end

  assign strobe_o       = busy_o;
  assign sorted_value_o = cell_value[0];
  assign final_item_o   = busy_o && (cnt_q == CNT_W'(1));
  assign overflowed_o   = busy_o && ovf_q;

`ifndef NO_ASSERTIONS
  a_drain_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (cnt_q != '0))
    else $error("drain with empty row");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  a_close_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && set_end_i |=> strobe_o)
    else $error("closing word did not start results");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !final_item_o |=> strobe_o)
    else $error("result burst broke before final word");

  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && final_item_o |=> !busy_o && (cnt_q == '0) && !ovf_q)
    else $error("block not cleared after final word");

  a_ovf_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full |=> ovf_q)
    else $error("dropped word not flagged");
`endif

endmodule

/* bench/insertion_sorter_checker.sv */
module insertion_sorter_checker #(
  parameter int MAX_ITEMS  = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                         set_end_i,
  input  logic                         strobe_i,
  input  logic signed [VALUE_BITS-1:0] sorted_value_i,
  input  logic                         final_item_i,
  input  logic                         overflowed_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef logic signed [VALUE_BITS-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  final_item;
    logic  overflowed;
  } sorted_word_t;

  word_t        held_words[$];
  logic         words_dropped = 1'b0;
  sorted_word_t due_words[$];
  int           mismatches = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = due_words.size();

  task automatic take_word(input word_t w, input logic closes);
    int           pos;
    sorted_word_t r;
    if (held_words.size() < MAX_ITEMS) begin
      pos = held_words.size();
      while (pos > 0 && held_words[pos-1] > w) pos--;
      held_words.insert(pos, w);
    end else begin
      words_dropped = 1'b1;
    end
    if (closes) begin
      for (int i = 0; i < held_words.size(); i++) begin
        r.value      = held_words[i];
        r.final_item = (i == held_words.size() - 1);
        r.overflowed = words_dropped;
        due_words.insert(due_words.size(), r);
      end
      held_words.delete();
      words_dropped = 1'b0;
    end
  endtask

  task automatic compare_word();
    sorted_word_t want;
    if (due_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected word value=%0d final=%b ovf=%b", $realtime,
                 sorted_value_i, final_item_i, overflowed_i);
    end else begin
      want = due_words.pop_front();
      if (want.value !== sorted_value_i || want.final_item !== final_item_i ||
          want.overflowed !== overflowed_i) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp value=%0d final=%b ovf=%b, got value=%0d final=%b ovf=%b",
                   $realtime, want.value, want.final_item, want.overflowed,
                   sorted_value_i, final_item_i, overflowed_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_words.delete();
      due_words.delete();
      words_dropped = 1'b0;
    end else begin
      if (strobe_i) compare_word();
      if (start_i && !busy_i) take_word(value_i, set_end_i);
    end
  end

endmodule

/* bench/insertion_sorter_test.sv */
module insertion_sorter_test;

  localparam int MAX_ITEMS  = 32;
  localparam int VALUE_BITS = 32;
  localparam int LIMIT      = 200000;
  localparam int PLAN_LEN   = 20;

  localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

  localparam logic signed [31:0] PLAN_VALUE [PLAN_LEN] = '{
    WORD_MAX,
    WORD_MIN,
    0, -1, 1, WORD_MAX, WORD_MIN, -1, 0,
    5, 4, 3, 2, 1,
    1, 2, 3,
    32'sh55555555, 32'shaaaaaaaa, 32'sh55555555
  };
  localparam bit PLAN_END [PLAN_LEN] = '{
    1,
    1,
    0, 0, 0, 0, 0, 0, 1,
    0, 0, 0, 0, 1,
    0, 0, 1,
    0, 0, 1
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic signed [VALUE_BITS-1:0] value_i;
  logic                         set_end_i;
  logic                         strobe_o;
  logic signed [VALUE_BITS-1:0] sorted_value_o;
  logic                         final_item_o;
  logic                         overflowed_o;
  int                           fail_count;
  int                           pending;
  int                           cycle_count = 0;

  insertion_sorter #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .set_end_i     (set_end_i),
    .strobe_o      (strobe_o),
    .sorted_value_o(sorted_value_o),
    .final_item_o  (final_item_o),
    .overflowed_o  (overflowed_o)
  );

  insertion_sorter_checker #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .value_i       (value_i),
    .set_end_i     (set_end_i),
    .strobe_i      (strobe_o),
    .sorted_value_i(sorted_value_o),
    .final_item_i  (final_item_o),
    .overflowed_i  (overflowed_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2, 3:    return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // present one word, hold it until taken
  task automatic send_word(input logic signed [31:0] w, input logic closes, input int gap);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i   = 1'b1;
    value_i   = w;
    set_end_i = closes;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_wait();
    start_i = 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int  set_size;
    int  sent;
    bit  quiet;
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    value_i   = '0;
    set_end_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++)
      send_word(PLAN_VALUE[i], PLAN_END[i], (i < 9) ? 0 : $urandom_range(0, 16));
    drain_wait();

    sent = 0;
    while (sent < 100) begin
      case ($urandom_range(0, 9))
        0:       set_size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
        1:       set_size = MAX_ITEMS;
        default: set_size = $urandom_range(1, 8);
      endcase
      if (sent == 0) set_size = MAX_ITEMS + 4;
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_size; i++)
        send_word(random_word(), i == set_size - 1, quiet ? 0 : $urandom_range(0, 16));
      sent += set_size;
      if ($urandom_range(0, 3) == 0) drain_wait();
    end

    drain_wait();
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/isort_pkg.sv
hdl/isort_cell.sv
hdl/insertion_sorter.sv
bench/insertion_sorter_checker.sv
bench/insertion_sorter_test.sv
